@@ sv/ccpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpe_pkg
// Shared types and constants for the cubic curve point evaluator: curve
// modes, register indexes, rounding kinds and the pipeline enable bundle.
// ----------------------------------------------------------------------------
package ccpe_pkg;

	// fixed field widths, point count and stage count
	localparam int T_W        = 16;
	localparam int OUT_W      = 18;
	localparam int CP_W       = 64;
	localparam int IDX_W      = 3;
	localparam int NUM_PTS    = 4;
	localparam int NUM_STAGES = 7;

	// curve mode register codes
	typedef enum logic [2:0] {
		MODE_LINEAR  = 3'd0,
		MODE_BEZIER  = 3'd1,
		MODE_CATMULL = 3'd2,
		MODE_HERMITE = 3'd3,
		MODE_BSPLINE = 3'd4
	} curve_mode_t;

	// register indexes on the write port
	localparam logic [IDX_W-1:0] CFG_MODE = 3'd0;
	localparam logic [IDX_W-1:0] CFG_CP0  = 3'd1;
	localparam logic [IDX_W-1:0] CFG_CP1  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_CP2  = 3'd3;
	localparam logic [IDX_W-1:0] CFG_CP3  = 3'd4;

	// weight scale of the blended sum: 1, 2 or 6 units of t
	typedef enum logic [1:0] {
		RND_ONE,
		RND_TWO,
		RND_SIX
	} round_kind_t;

	// saturation limits of the result
	localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pipe_en_t;

endpackage

@@ sv/ccpe_powers.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpe_powers
// Stages 1 and 2: clamps t, forms u = 1 - t and the rounded power products
// t^2, u^2, then t^3, u^3, u^2*t and u*t^2.
// ----------------------------------------------------------------------------
module ccpe_powers import ccpe_pkg::*; #(
	parameter int PARAM_FRAC_BITS = 15
) (
	input  logic                     clk,
	input  pipe_en_t                 en,
	input  logic [T_W-1:0]           param_t,
	output logic [PARAM_FRAC_BITS:0] t_s2,
	output logic [PARAM_FRAC_BITS:0] t2_s2,
	output logic [PARAM_FRAC_BITS:0] t3_s2,
	output logic [PARAM_FRAC_BITS:0] u3_s2,
	output logic [PARAM_FRAC_BITS:0] u2t_s2,
	output logic [PARAM_FRAC_BITS:0] ut2_s2
);

	localparam int F  = PARAM_FRAC_BITS;
	localparam int PW = 2 * F + 2;
	localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};
	localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

	// product rounded to nearest, back to F fraction bits
	function automatic logic [F:0] rmul(input logic [F:0] a, input logic [F:0] b);
		logic [PW-1:0] p;
		p = PW'(a) * PW'(b) + HALF;
		return p[F +: F + 1];
	endfunction

	logic [F:0] t_c;
	logic [F:0] u_c;
	logic [F:0] t_s1;
	logic [F:0] u_s1;
	logic [F:0] t2_s1;
	logic [F:0] u2_s1;

	// clamp t to one and form u
	always_comb begin
		t_c = (param_t > T_W'(ONE)) ? ONE : param_t[F:0];
		u_c = ONE - t_c;
	end

	// stage 1: squares
	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1  <= t_c;
			u_s1  <= u_c;
			t2_s1 <= rmul(t_c, t_c);
			u2_s1 <= rmul(u_c, u_c);
		end
	end

	// stage 2: cubes and mixed terms
	always_ff @(posedge clk) begin
		if (en.s2) begin
			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			t3_s2  <= rmul(t2_s1, t_s1);
			u3_s2  <= rmul(u2_s1, u_s1);
			u2t_s2 <= rmul(u2_s1, t_s1);
			ut2_s2 <= rmul(u_s1, t2_s1);
		end
	end

endmodule

@@ sv/ccpe_weights.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpe_weights
// Stage 3: builds the four basis weights of the selected curve mode from
// the powers of t, as exact integers at a scale of one, two or six.
// ----------------------------------------------------------------------------
module ccpe_weights import ccpe_pkg::*; #(
	parameter int PARAM_FRAC_BITS = 15
) (
	input  logic                            clk,
	input  pipe_en_t                        en,
	input  curve_mode_t                     mode,
	input  logic [PARAM_FRAC_BITS:0]        t_s2,
	input  logic [PARAM_FRAC_BITS:0]        t2_s2,
	input  logic [PARAM_FRAC_BITS:0]        t3_s2,
	input  logic [PARAM_FRAC_BITS:0]        u3_s2,
	input  logic [PARAM_FRAC_BITS:0]        u2t_s2,
	input  logic [PARAM_FRAC_BITS:0]        ut2_s2,
	output logic signed [PARAM_FRAC_BITS+3:0] w_s3 [NUM_PTS],
	output round_kind_t                     kind_s3
);

	localparam int F  = PARAM_FRAC_BITS;
	localparam int WW = F + 4;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	logic signed [WW-1:0] one;
	logic signed [WW-1:0] ti;
	logic signed [WW-1:0] t2;
	logic signed [WW-1:0] t3;
	logic signed [WW-1:0] u3;
	logic signed [WW-1:0] u2t;
	logic signed [WW-1:0] ut2;
	logic signed [WW-1:0] ti_x3;
	logic signed [WW-1:0] t2_x3;
	logic signed [WW-1:0] t3_x3;
	logic signed [WW-1:0] w [NUM_PTS];
	round_kind_t          kind;

	// powers widened to signed weight width, plus the times-three terms
	always_comb begin
		one   = WW'(ONE);
		ti    = WW'(t_s2);
		t2    = WW'(t2_s2);
		t3    = WW'(t3_s2);
		u3    = WW'(u3_s2);
		u2t   = WW'(u2t_s2);
		ut2   = WW'(ut2_s2);
		ti_x3 = (ti <<< 1) + ti;
		t2_x3 = (t2 <<< 1) + t2;
		t3_x3 = (t3 <<< 1) + t3;
	end

	// basis weights per mode
	always_comb begin
		w    = '{default: '0};
		kind = RND_ONE;
		case (mode)
			MODE_BEZIER: begin
				w[0] = u3;
				w[1] = (u2t <<< 1) + u2t;
				w[2] = (ut2 <<< 1) + ut2;
				w[3] = t3;
			end
			MODE_CATMULL: begin
				kind = RND_TWO;
				w[0] = (t2 <<< 1) - ti - t3;
				w[1] = (one <<< 1) - (t2 <<< 2) - t2 + t3_x3;
				w[2] = ti + (t2 <<< 2) - t3_x3;
				w[3] = t3 - t2;
			end
			MODE_HERMITE: begin
				w[0] = one - ti - t2 + t3;
				w[1] = (t2 <<< 2) - t3_x3;
				w[2] = ti - (t2 <<< 1) + t3;
				w[3] = t3 - t2;
			end
			MODE_BSPLINE: begin
				kind = RND_SIX;
				w[0] = one - ti_x3 + t2_x3 - t3;
				w[1] = (one <<< 2) - (t2 <<< 2) - (t2 <<< 1) + t3_x3;
				w[2] = one + ti_x3 + t2_x3 - t3_x3;
				w[3] = t3;
			end
			default: begin
				w[0] = one - ti;
				w[1] = ti;
			end
		endcase
	end

	// stage 3 register
	always_ff @(posedge clk) begin
		if (en.s3) begin
			w_s3    <= w;
			kind_s3 <= kind;
		end
	end

endmodule

@@ sv/ccpe_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpe_blend
// Stages 4 and 5 for one component: four weight-by-point products, then
// their exact sum with the rounding offset of the weight scale added.
// ----------------------------------------------------------------------------
module ccpe_blend import ccpe_pkg::*; #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int PARAM_FRAC_BITS = 15
) (
	input  logic                                           clk,
	input  pipe_en_t                                       en,
	input  logic signed [PARAM_FRAC_BITS+3:0]              w_s3 [NUM_PTS],
	input  round_kind_t                                    kind_s3,
	input  logic signed [COMPONENT_WIDTH-1:0]              comp [NUM_PTS],
	output logic signed [PARAM_FRAC_BITS+COMPONENT_WIDTH+5:0] acc_s5,
	output round_kind_t                                    kind_s5
);

	localparam int F  = PARAM_FRAC_BITS;
	localparam int WW = F + 4;
	localparam int MW = WW + COMPONENT_WIDTH;
	localparam int SW = MW + 2;

	logic signed [MW-1:0] prod_s4 [NUM_PTS];
	round_kind_t          kind_s4;
	logic signed [SW-1:0] rnd;

	// stage 4: products
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int k = 0; k < NUM_PTS; k++) begin
				prod_s4[k] <= MW'(w_s3[k]) * MW'(comp[k]);
			end
			kind_s4 <= kind_s3;
		end
	end

	// half of the weight scale
	always_comb begin
		case (kind_s4)
			RND_TWO: rnd = SW'(1) <<< F;
			RND_SIX: rnd = SW'(3) <<< F;
			default: rnd = SW'(1) <<< (F - 1);
		endcase
	end

	// stage 5: sum plus rounding offset
	always_ff @(posedge clk) begin
		if (en.s5) begin
			acc_s5  <= SW'(prod_s4[0]) + SW'(prod_s4[1]) + SW'(prod_s4[2])
				+ SW'(prod_s4[3]) + rnd;
			kind_s5 <= kind_s4;
		end
	end

endmodule

@@ sv/ccpe_round_sat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpe_round_sat
// Stages 6 and 7 for one component: floor division of the rounded sum by
// the weight scale (shift, and a reciprocal multiply for the factor of
// three), then saturation to the 18-bit result.
// ----------------------------------------------------------------------------
module ccpe_round_sat import ccpe_pkg::*; #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int PARAM_FRAC_BITS = 15
) (
	input  logic                                             clk,
	input  pipe_en_t                                         en,
	input  logic signed [PARAM_FRAC_BITS+COMPONENT_WIDTH+5:0] acc_s5,
	input  round_kind_t                                      kind_s5,
	output logic signed [OUT_W-1:0]                          out_s7
);

	localparam int F  = PARAM_FRAC_BITS;
	localparam int CW = COMPONENT_WIDTH;
	localparam int SW = F + CW + 6;
	localparam int QW = CW + 5;
	localparam int VW = CW + 6;
	localparam int DW = CW + 6;
	localparam int K  = DW + 1;
	localparam int EW = (VW > OUT_W) ? VW : OUT_W;
	// ceil(2^K / 3): exact floor quotient for every biased value below 2^DW
	localparam logic [DW-1:0] RECIP = DW'((2 ** K + 2) / 3);
	// bias that keeps the dividend positive, a multiple of three
	localparam logic [DW-1:0] BIAS3 = DW'(3) << (CW + 4);
	localparam logic [VW-1:0] BIAS1 = VW'(1) << (CW + 4);

	logic signed [VW-1:0] v_one;
	logic signed [QW-1:0] q_two;
	logic [DW-1:0]        n_six;
	logic signed [VW-1:0] lin_s6;
	logic [2*DW-1:0]      prod_s6;
	logic                 six_s6;
	logic [DW-2:0]        d_six;
	logic signed [VW-1:0] v_six;
	logic signed [EW-1:0] v_ext;

	// arithmetic shifts by the power-of-two part of the scale
	always_comb begin
		v_one = $signed(acc_s5[SW-1:F]);
		q_two = $signed(acc_s5[SW-1:F+1]);
		n_six = DW'(q_two) + BIAS3;
	end

	// stage 6: shifted value, and the reciprocal product for scale six
	always_ff @(posedge clk) begin
		if (en.s6) begin
			lin_s6  <= (kind_s5 == RND_ONE) ? v_one : VW'(q_two);
			prod_s6 <= (2 * DW)'(n_six) * (2 * DW)'(RECIP);
			six_s6  <= (kind_s5 == RND_SIX);
		end
	end

	// remove the bias and pick the path
	always_comb begin
		d_six = prod_s6[2*DW-1:K];
		v_six = VW'(d_six) - BIAS1;
		v_ext = six_s6 ? EW'(v_six) : EW'(lin_s6);
	end

	// stage 7: saturation and output register
	always_ff @(posedge clk) begin
		if (en.s7) begin
			if (v_ext > EW'(OUT_MAX)) begin
				out_s7 <= OUT_MAX;
			end else if (v_ext < EW'(OUT_MIN)) begin
				out_s7 <= OUT_MIN;
			end else begin
				out_s7 <= OUT_W'(v_ext);
			end
		end
	end

endmodule

@@ sv/cubic_curve_point_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_curve_point_evaluator
// Evaluates one point of a linear, Bezier, Catmull-Rom, Hermite or uniform
// B-spline curve at parameter t from four four-component control points.
//
//   channel  | dir | handshake              | payload
//   s_axis   | in  | tvalid / tready        | tdata: param_t
//   m_axis   | out | tvalid / tready        | tdata: out_x, out_y, out_z, out_w
//   wr       | in  | wr_en                  | wr_index, wr_data
//
// One request enters per cycle while stage 1 can load; a taken request passes
// through the stages in order (powers: 2 stages, weights: 1, products and sum: 2,
// scale division and saturation: 2). Reset clears the stage valid bits and
// the configuration registers. A stalled output holds only the stages that are
// full; empty stages keep filling, so input is taken while a result waits.
// ----------------------------------------------------------------------------
module cubic_curve_point_evaluator import ccpe_pkg::*; #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int PARAM_FRAC_BITS = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [T_W-1:0]       s_axis_tdata,   // [15:0] param_t
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [4*OUT_W-1:0]   m_axis_tdata,   // [17:0] x, [35:18] y, [53:36] z, [71:54] w
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_index,
	input  logic [CP_W-1:0]      wr_data
);

	localparam int F  = PARAM_FRAC_BITS;
	localparam int CW = COMPONENT_WIDTH;

	curve_mode_t            mode_q;
	logic [CP_W-1:0]        cp_q [NUM_PTS];
	logic [NUM_STAGES:1]    stage_vld_q;
	logic [NUM_STAGES+1:1]  en_vec;
	pipe_en_t               en;

	logic [F:0]             t_s2;
	logic [F:0]             t2_s2;
	logic [F:0]             t3_s2;
	logic [F:0]             u3_s2;
	logic [F:0]             u2t_s2;
	logic [F:0]             ut2_s2;
	logic signed [F+3:0]    w_s3 [NUM_PTS];
	round_kind_t            kind_s3;
	logic signed [OUT_W-1:0] out_s7 [NUM_PTS];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			for (int k = 0; k < NUM_PTS; k++) begin
				cp_q[k] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				CFG_MODE: mode_q  <= curve_mode_t'(wr_data[2:0]);
				CFG_CP0:  cp_q[0] <= wr_data;
				CFG_CP1:  cp_q[1] <= wr_data;
				CFG_CP2:  cp_q[2] <= wr_data;
				CFG_CP3:  cp_q[3] <= wr_data;
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when the stage after it moves on
	always_comb begin
		en_vec[NUM_STAGES+1] = m_axis_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			en_vec[k] = ~stage_vld_q[k] | en_vec[k+1];
		end
		en.s1 = en_vec[1];
		en.s2 = en_vec[2];
		en.s3 = en_vec[3];
		en.s4 = en_vec[4];
		en.s5 = en_vec[5];
		en.s6 = en_vec[6];
		en.s7 = en_vec[7];
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en_vec[1]) begin
				stage_vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en_vec[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = en_vec[1];
	assign m_axis_tvalid = stage_vld_q[NUM_STAGES];

	// powers of t and u
	ccpe_powers #(
		.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
	) u_powers (
		.clk    (clk),
		.en     (en),
		.param_t(s_axis_tdata),
		.t_s2   (t_s2),
		.t2_s2  (t2_s2),
		.t3_s2  (t3_s2),
		.u3_s2  (u3_s2),
		.u2t_s2 (u2t_s2),
		.ut2_s2 (ut2_s2)
	);

	// basis weights
	ccpe_weights #(
		.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
	) u_weights (
		.clk    (clk),
		.en     (en),
		.mode   (mode_q),
		.t_s2   (t_s2),
		.t2_s2  (t2_s2),
		.t3_s2  (t3_s2),
		.u3_s2  (u3_s2),
		.u2t_s2 (u2t_s2),
		.ut2_s2 (ut2_s2),
		.w_s3   (w_s3),
		.kind_s3(kind_s3)
	);

	// one blend and rounding lane per component
	for (genvar c = 0; c < NUM_PTS; c++) begin : g_lane
		logic signed [CW-1:0]      comp [NUM_PTS];
		logic signed [F+CW+5:0]    acc_s5;
		round_kind_t               kind_s5;

		for (genvar k = 0; k < NUM_PTS; k++) begin : g_pt
			assign comp[k] = $signed(cp_q[k][c*CW +: CW]);
		end

		ccpe_blend #(
			.COMPONENT_WIDTH(COMPONENT_WIDTH),
			.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
		) u_blend (
			.clk    (clk),
			.en     (en),
			.w_s3   (w_s3),
			.kind_s3(kind_s3),
			.comp   (comp),
			.acc_s5 (acc_s5),
			.kind_s5(kind_s5)
		);

		ccpe_round_sat #(
			.COMPONENT_WIDTH(COMPONENT_WIDTH),
			.PARAM_FRAC_BITS(PARAM_FRAC_BITS)
		) u_round_sat (
			.clk    (clk),
			.en     (en),
			.acc_s5 (acc_s5),
			.kind_s5(kind_s5),
			.out_s7 (out_s7[c])
		);

		assign m_axis_tdata[c*OUT_W +: OUT_W] = out_s7[c];
	end

	// a taken request occupies stage 1 on the next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> stage_vld_q[1])
		else $error("accepted request did not enter stage 1");

	// a full stage that was held stays full
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((stage_vld_q & $past(stage_vld_q & ~en_vec[NUM_STAGES:1]))
			== $past(stage_vld_q & ~en_vec[NUM_STAGES:1])))
		else $error("held pipeline stage lost its request");

	// a delivered result with nothing behind it is not shown again
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !stage_vld_q[NUM_STAGES-1] |=> !m_axis_tvalid)
		else $error("result repeated after delivery");

endmodule

@@ test/cubic_curve_point_evaluator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_curve_point_evaluator_tb
// Stream-level test of the curve point evaluator. An in-bench fixed-point
// model predicts x, y, z, w for every accepted parameter, and each result is
// checked in order against it. The run covers directed extremes in every
// curve mode, then random control points and parameters under random
// backpressure and source gaps, including one long output stall.
// ----------------------------------------------------------------------------
module cubic_curve_point_evaluator_tb;
	import ccpe_pkg::*;

	localparam int CW          = 16;
	localparam int FB          = 15;
	localparam longint T_ONE   = 64'd1 << FB;
	localparam longint T_HALF  = 64'd1 << (FB - 1);
	localparam int SETTLE      = NUM_STAGES + 5;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 12;
	localparam int PHASE_ITEMS = 150;
	localparam int PRESSURE_PH = 3;
	localparam int QUIET_PH    = 6;

	// spare mode code that must behave as linear
	localparam logic [2:0] MODE_SPARE = 3'd7;
	// first register index with nothing behind it
	localparam logic [IDX_W-1:0] CFG_NONE = CFG_CP3 + 1'b1;

	typedef struct packed {
		logic signed [OUT_W-1:0] w;
		logic signed [OUT_W-1:0] z;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] x;
	} point_t;

	// ------------------------------------------------------------------------
	// curve point predictor and in-order result store
	// ------------------------------------------------------------------------
	class curve_point_checker;
		logic [2:0]      mode;
		logic [CP_W-1:0] ctrl [NUM_PTS];
		point_t          expected_points [$];
		int              mismatches;
		int              requests_seen;
		int              points_seen;

		function new();
			mode = MODE_LINEAR;
			foreach (ctrl[k]) ctrl[k] = '0;
			mismatches    = 0;
			requests_seen = 0;
			points_seen   = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CP_W-1:0] data);
			if (idx == CFG_MODE)
				mode = data[2:0];
			else if (idx <= CFG_CP3)
				ctrl[idx - CFG_CP0] = data;
		endfunction

		function longint component(logic [CP_W-1:0] word, int c);
			logic signed [CW-1:0] v;
			v = word[c*CW +: CW];
			return longint'(v);
		endfunction

		function longint round_mul(longint a, longint b);
			return (a * b + T_HALF) >>> FB;
		endfunction

		// divide by the weight scale, halves toward plus infinity, then clamp
		function logic signed [OUT_W-1:0] scale_round_sat(longint sum, longint scale);
			longint n;
			longint d;
			longint q;
			n = 2 * sum + scale;
			d = 2 * scale;
			q = n / d;
			if ((n % d) != 0 && n < 0)
				q = q - 1;
			if (q > longint'(OUT_MAX))
				q = longint'(OUT_MAX);
			if (q < longint'(OUT_MIN))
				q = longint'(OUT_MIN);
			return q[OUT_W-1:0];
		endfunction

		function point_t eval_point(logic [T_W-1:0] t_raw);
			longint t;
			longint t2;
			longint t3;
			longint u;
			longint u2;
			longint one;
			longint scale;
			longint sum;
			longint wt [NUM_PTS];
			logic [4*OUT_W-1:0] flat;
			one = T_ONE;
			// parameters beyond one clamp to one
			t = (longint'(t_raw) > T_ONE) ? T_ONE : longint'(t_raw);
			t2 = round_mul(t, t);
			t3 = round_mul(t2, t);
			scale = one;
			case (mode)
				MODE_BEZIER: begin
					u = one - t;
					u2 = round_mul(u, u);
					wt[0] = round_mul(u2, u);
					wt[1] = 3 * round_mul(u2, t);
					wt[2] = 3 * round_mul(u, t2);
					wt[3] = t3;
				end
				MODE_CATMULL: begin
					scale = 2 * one;
					wt[0] = -t + 2 * t2 - t3;
					wt[1] = 2 * one - 5 * t2 + 3 * t3;
					wt[2] = t + 4 * t2 - 3 * t3;
					wt[3] = -t2 + t3;
				end
				MODE_HERMITE: begin
					// endpoint blends minus tangent blends fold the p2-p0, p3-p1 tangents
					wt[2] = t - 2 * t2 + t3;
					wt[3] = -t2 + t3;
					wt[0] = (one - 3 * t2 + 2 * t3) - wt[2];
					wt[1] = (3 * t2 - 2 * t3) - wt[3];
				end
				MODE_BSPLINE: begin
					scale = 6 * one;
					wt[0] = one - 3 * t + 3 * t2 - t3;
					wt[1] = 4 * one - 6 * t2 + 3 * t3;
					wt[2] = one + 3 * t + 3 * t2 - 3 * t3;
					wt[3] = t3;
				end
				default: begin
					// linear, also taken by the unused mode codes
					wt[0] = one - t;
					wt[1] = t;
					wt[2] = 0;
					wt[3] = 0;
				end
			endcase
			for (int c = 0; c < 4; c++) begin
				sum = 0;
				for (int k = 0; k < NUM_PTS; k++)
					sum += wt[k] * component(ctrl[k], c);
				flat[c*OUT_W +: OUT_W] = scale_round_sat(sum, scale);
			end
			return point_t'(flat);
		endfunction

		function void note_request(logic [T_W-1:0] t_raw);
			expected_points.push_back(eval_point(t_raw));
			requests_seen++;
		endfunction

		function void check_point(logic [4*OUT_W-1:0] data);
			logic [4*OUT_W-1:0] want;
			logic signed [OUT_W-1:0] e;
			logic signed [OUT_W-1:0] a;
			string names [4];
			names = '{"out_x", "out_y", "out_z", "out_w"};
			points_seen++;
			if (expected_points.size() == 0) begin
				mismatches++;
				$error("result with no request pending: %h", data);
				return;
			end
			want = expected_points.pop_front();
			for (int c = 0; c < 4; c++) begin
				e = want[c*OUT_W +: OUT_W];
				a = data[c*OUT_W +: OUT_W];
				if (e !== a) begin
					mismatches++;
					$error("%s: expected %0d, got %0d", names[c], e, a);
				end
			end
		endfunction

		function int pending();
			return expected_points.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [T_W-1:0]       s_axis_tdata;   // [15:0] param_t
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [4*OUT_W-1:0]   m_axis_tdata;   // [17:0] x, [35:18] y, [53:36] z, [71:54] w
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_index;
	logic [CP_W-1:0]      wr_data;

	curve_point_checker sb = new();

	bit send_quiet;
	bit recv_quiet;
	bit hold_req;
	int n_settings;

	cubic_curve_point_evaluator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	initial begin
		#10ms;
		$display("cubic_curve_point_evaluator_tb: done, errors");
		$finish;
	end

	// handshake monitor: requests feed the predictor, results get checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_point(m_axis_tdata);
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// output side: random stalls, and one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				int stall;
				stall = gap_len(recv_quiet);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	function automatic logic [T_W-1:0] rand_t();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return ($urandom_range(0, 1) != 0) ? T_ONE[T_W-1:0] : '0;
		if (r < 25)
			return T_W'($urandom_range(0, 16'hFFFF));
		return T_W'($urandom_range(0, int'(T_ONE)));
	endfunction

	function automatic logic [CP_W-1:0] rand_point();
		logic [CP_W-1:0] p;
		logic [CW-1:0] v;
		for (int c = 0; c < 4; c++) begin
			case ($urandom_range(0, 9))
				0: v = 16'h7FFF;
				1: v = 16'h8000;
				2: v = 16'h0000;
				3: v = 16'hFFFF;
				default: v = CW'($urandom);
			endcase
			p[c*CW +: CW] = v;
		end
		return p;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CP_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// write mode and all four points, optionally poke an unmapped index
	task automatic configure(input logic [CP_W-1:0] mode_word,
	                         input logic [CP_W-1:0] pts [NUM_PTS], input bit poke_spare);
		write_reg(CFG_MODE, mode_word);
		for (int k = 0; k < NUM_PTS; k++)
			write_reg(CFG_CP0 + IDX_W'(k), pts[k]);
		if (poke_spare)
			write_reg(IDX_W'($urandom_range(CFG_NONE, 2**IDX_W - 1)),
			          {$urandom, $urandom});
		wr_en <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic send_point(input logic [T_W-1:0] t);
		int gap;
		gap = gap_len(send_quiet);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= t;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// stop sending and let the pipeline empty before touching registers
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// main sequence
	initial begin
		logic [CP_W-1:0] pts [NUM_PTS];
		logic [CP_W-1:0] mode_word;
		logic [T_W-1:0]  dir_t [4];

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		wr_en         = 1'b0;
		wr_index      = '0;
		wr_data       = '0;
		send_quiet    = 1'b0;
		recv_quiet    = 1'b0;
		hold_req      = 1'b0;
		n_settings    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset registers: all points zero, linear
		send_point('0);
		send_point(T_ONE[T_W-1:0]);
		drain();

		// extreme points through every mode, at both ends, midpoint and beyond one
		pts[0] = {4{16'h8000}};
		pts[1] = {4{16'h7FFF}};
		pts[2] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
		pts[3] = ~pts[2];
		dir_t  = '{16'h0000, T_HALF[T_W-1:0], T_ONE[T_W-1:0], 16'hFFFF};
		for (int m = MODE_LINEAR; m <= MODE_BSPLINE; m++) begin
			configure(CP_W'(m), pts, 1'b0);
			foreach (dir_t[i])
				send_point(dir_t[i]);
			drain();
		end

		// unused mode code with high junk bits, plus a write to an unmapped index
		configure({{(CP_W-3){1'b1}}, MODE_SPARE}, pts, 1'b1);
		send_point(T_W'(T_ONE / 3));
		send_point(T_ONE[T_W-1:0] + 1'b1);
		drain();

		// random phases, sweeping all eight mode codes
		for (int ph = 0; ph < N_PHASES; ph++) begin
			foreach (pts[k])
				pts[k] = rand_point();
			mode_word = {$urandom, $urandom};
			mode_word[2:0] = 3'(ph % 8);
			configure(mode_word, pts, $urandom_range(0, 1) != 0);
			send_quiet = (ph == QUIET_PH) || (ph == PRESSURE_PH);
			recv_quiet = (ph == QUIET_PH);
			if (ph == PRESSURE_PH)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				send_point(rand_t());
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d register settings",
		         sb.requests_seen, sb.points_seen, n_settings);
		$display("all curve modes and spare codes, clamped t, long output stall");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("cubic_curve_point_evaluator_tb: done, clean");
		else
			$display("cubic_curve_point_evaluator_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/ccpe_pkg.sv
sv/ccpe_powers.sv
sv/ccpe_weights.sv
sv/ccpe_blend.sv
sv/ccpe_round_sat.sv
sv/cubic_curve_point_evaluator.sv
test/cubic_curve_point_evaluator_tb.sv
